// File: rtl/core/scl_pkg.sv
// Shared types and constants for the sector cache LRU controller.
`timescale 1ns / 1ps

package scl_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int PIN_BITS_DEF  = 8;

   localparam int FUNC_W   = 2;
   localparam int SECTOR_W = 32;
   localparam int KIND_W   = 3;
   localparam int REL_W    = 6;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_GET     = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_FLUSH   = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HIT        = 3'd0,
      KIND_WB         = 3'd1,
      KIND_FILL       = 3'd2,
      KIND_REL_DONE   = 3'd3,
      KIND_FLUSH_DONE = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FLUSH,
      ST_EMIT_WB,
      ST_EMIT_LAST
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_HIT,
      OP_FILL,
      OP_REL,
      OP_CLR
   } slot_op_type;

   typedef struct packed {
      slot_op_type         op;
      logic                wr;
      logic [SECTOR_W-1:0] sector;
   } slot_cmd_type;

endpackage

// File: rtl/core/sector_cache_lru_controller.sv
// Top level of the sector cache LRU controller.
`timescale 1ns / 1ps

// Bookkeeping for a fully associative write-back sector cache with pin counts.
// One request is worked at a time. A get or a release is accepted, then updates
// the slot and ring cells and stages its results, which leave the output register
// one per cycle while the result channel takes them, a write-back result first
// where one is due. A flush sweeps the slot cells one per cycle, a slot with a
// write-back due waiting for a free result channel, sending that write-back in the sweep cycle of its slot.
// A stalled result channel holds the block in place. An unused function code
// is taken and dropped.

module sector_cache_lru_controller
   import scl_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int PIN_BITS  = PIN_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SECTOR_W-1:0] req_sector_address,
   input  logic [SECTOR_W-1:0] req_range_other_bound,
   input  logic                req_write_mode,
   input  logic [REL_W-1:0]    req_release_slot,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [REL_W-1:0]    rsp_slot,
   output logic [SECTOR_W-1:0] rsp_slot_sector,
   output logic                rsp_last
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);

   state_type state_ff, state_in;

   // latched request
   func_type            func_ff;
   logic [SECTOR_W-1:0] addr_ff, lo_ff, hi_ff;
   logic                wr_ff;
   logic [REL_W-1:0]    rel_ff;

   // staged results
   logic [SLOT_W-1:0]   wb_slot_ff, wb_slot_in;
   logic [SECTOR_W-1:0] wb_sector_ff, wb_sector_in;
   kind_type            fin_kind_ff, fin_kind_in;
   logic [REL_W-1:0]    fin_slot_ff, fin_slot_in;
   logic [SECTOR_W-1:0] fin_sector_ff, fin_sector_in;

   logic [SLOT_W-1:0]   idx_ff, idx_in;

   // output register
   logic                out_valid_ff, out_valid_in;
   kind_type            out_kind_ff, out_kind_in;
   logic [REL_W-1:0]    out_slot_ff, out_slot_in;
   logic [SECTOR_W-1:0] out_sector_ff, out_sector_in;
   logic                out_last_ff, out_last_in;
   logic                out_free;

   // cell row
   slot_cmd_type        cmd;
   logic [NUM_SLOTS-1:0] sel;
   logic [SECTOR_W-1:0] tag   [NUM_SLOTS];
   logic                valid [NUM_SLOTS];
   logic                dirty [NUM_SLOTS];
   logic [PIN_BITS-1:0] pins  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] match;

   logic [SLOT_W-1:0]   ring_id  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] ring_shift;
   logic [NUM_SLOTS:0]  ring_carry;
   logic [SLOT_W-1:0]   ring_front;
   logic                shift_all, shift_hit;

   logic                hit_any;
   logic [SLOT_W-1:0]   hit_idx, victim, rel_idx;
   logic                rel_ok, wb_need, flush_hit, flush_step, stage_load;

   assign out_free = !out_valid_ff || rsp_ready;
   assign victim   = ring_id[NUM_SLOTS-1];
   assign rel_idx  = rel_ff[SLOT_W-1:0];
   assign rel_ok   = 32'(rel_ff) < 32'(NUM_SLOTS);

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_any = 1'b1;
            hit_idx = SLOT_W'(i);
         end
      end
   end

   assign flush_hit = dirty[idx_ff] && (tag[idx_ff] >= lo_ff) && (tag[idx_ff] <= hi_ff);

   genvar g;
   generate
      for (g = 0; g < NUM_SLOTS; g++) begin : g_slot
         scl_slot_cell #(.PIN_BITS(PIN_BITS)) u_slot (
            .clock (clock),
            .reset (reset),
            .sel   (sel[g]),
            .cmd   (cmd),
            .tag   (tag[g]),
            .valid (valid[g]),
            .dirty (dirty[g]),
            .pins  (pins[g]),
            .match (match[g])
         );
      end

      assign ring_carry[NUM_SLOTS] = 1'b0;
      for (g = 0; g < NUM_SLOTS; g++) begin : g_ring
         // positions up to the hit one shift toward the back
         assign ring_carry[g] = (ring_id[g] == hit_idx) || ring_carry[g+1];
         assign ring_shift[g] = shift_all || (shift_hit && ring_carry[g]);
         if (g == 0) begin : g_front
            scl_ring_cell #(.ID_W(SLOT_W), .RESET_ID(NUM_SLOTS - 1)) u_ring (
               .clock    (clock),
               .reset    (reset),
               .shift    (ring_shift[g]),
               .shift_in (ring_front),
               .id       (ring_id[g])
            );
         end else begin : g_rest
            scl_ring_cell #(.ID_W(SLOT_W), .RESET_ID(NUM_SLOTS - 1 - g)) u_ring (
               .clock    (clock),
               .reset    (reset),
               .shift    (ring_shift[g]),
               .shift_in (ring_id[g-1]),
               .id       (ring_id[g])
            );
         end
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && func_type'(req_func) != FUNC_NONE) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (func_ff == FUNC_FLUSH) state_in = ST_FLUSH;
            else if (wb_need)          state_in = ST_EMIT_WB;
            else                       state_in = ST_EMIT_LAST;
         end
         ST_FLUSH: begin
            if (flush_step && idx_ff == SLOT_W'(NUM_SLOTS - 1)) state_in = ST_EMIT_LAST;
         end
         ST_EMIT_WB: begin
            if (out_free) state_in = ST_EMIT_LAST;
         end
         ST_EMIT_LAST: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.op        = OP_NONE;
      cmd.wr        = wr_ff;
      cmd.sector    = addr_ff;
      sel           = '0;
      shift_all     = 1'b0;
      shift_hit     = 1'b0;
      ring_front    = hit_idx;
      wb_need       = 1'b0;
      flush_step    = 1'b0;
      stage_load    = 1'b0;
      wb_slot_in    = wb_slot_ff;
      wb_sector_in  = wb_sector_ff;
      fin_kind_in   = fin_kind_ff;
      fin_slot_in   = fin_slot_ff;
      fin_sector_in = fin_sector_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_sector_in = out_sector_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            idx_in    = '0;
         end
         ST_EXEC: begin
            stage_load = 1'b1;
            unique case (func_ff)
               FUNC_GET: begin
                  if (hit_any) begin
                     cmd.op           = OP_HIT;
                     sel[hit_idx]     = 1'b1;
                     shift_hit        = 1'b1;
                     fin_kind_in      = KIND_HIT;
                     fin_slot_in      = REL_W'(hit_idx);
                     fin_sector_in    = tag[hit_idx];
                  end else begin
                     cmd.op           = OP_FILL;
                     sel[victim]      = 1'b1;
                     shift_all        = 1'b1;
                     ring_front       = victim;
                     wb_need          = dirty[victim] && pins[victim] == '0;
                     wb_slot_in       = victim;
                     wb_sector_in     = tag[victim];
                     fin_kind_in      = KIND_FILL;
                     fin_slot_in      = REL_W'(victim);
                     fin_sector_in    = addr_ff;
                  end
               end
               FUNC_RELEASE: begin
                  if (rel_ok) begin
                     cmd.op           = OP_REL;
                     sel[rel_idx]     = 1'b1;
                     wb_need          = dirty[rel_idx] && pins[rel_idx] <= PIN_BITS'(1);
                  end
                  wb_slot_in    = rel_idx;
                  wb_sector_in  = tag[rel_idx];
                  fin_kind_in   = KIND_REL_DONE;
                  fin_slot_in   = rel_ff;
                  fin_sector_in = '0;
               end
               default: begin
                  fin_kind_in   = KIND_FLUSH_DONE;
                  fin_slot_in   = '0;
                  fin_sector_in = '0;
               end
            endcase
         end
         ST_FLUSH: begin
            if (!flush_hit) begin
               flush_step = 1'b1;
            end else if (out_free) begin
               flush_step    = 1'b1;
               cmd.op        = OP_CLR;
               sel[idx_ff]   = 1'b1;
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_WB;
               out_slot_in   = REL_W'(idx_ff);
               out_sector_in = tag[idx_ff];
               out_last_in   = 1'b0;
            end
            if (flush_step) idx_in = idx_ff + SLOT_W'(1);
         end
         ST_EMIT_WB: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_WB;
               out_slot_in   = REL_W'(wb_slot_ff);
               out_sector_in = wb_sector_ff;
               out_last_in   = 1'b0;
            end
         end
         ST_EMIT_LAST: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = fin_kind_ff;
               out_slot_in   = fin_slot_ff;
               out_sector_in = fin_sector_ff;
               out_last_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= func_type'(req_func);
         addr_ff <= req_sector_address;
         wr_ff   <= req_write_mode;
         rel_ff  <= req_release_slot;
         // swap reversed bounds
         if (req_sector_address > req_range_other_bound) begin
            lo_ff <= req_range_other_bound;
            hi_ff <= req_sector_address;
         end else begin
            lo_ff <= req_sector_address;
            hi_ff <= req_range_other_bound;
         end
      end
      if (stage_load) begin
         wb_slot_ff    <= wb_slot_in;
         wb_sector_ff  <= wb_sector_in;
         fin_kind_ff   <= fin_kind_in;
         fin_slot_ff   <= fin_slot_in;
         fin_sector_ff <= fin_sector_in;
      end
      idx_ff        <= idx_in;
      out_kind_ff   <= out_kind_in;
      out_slot_ff   <= out_slot_in;
      out_sector_ff <= out_sector_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_slot        = out_slot_ff;
   assign rsp_slot_sector = out_sector_ff;
   assign rsp_last        = out_last_ff;

endmodule

// File: rtl/core/scl_slot_cell.sv
// One cache slot: tag, valid, dirty and saturating pin count.
`timescale 1ns / 1ps

module scl_slot_cell
   import scl_pkg::*;
#(
   parameter int PIN_BITS = PIN_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                sel,
   input  slot_cmd_type        cmd,
   output logic [SECTOR_W-1:0] tag,
   output logic                valid,
   output logic                dirty,
   output logic [PIN_BITS-1:0] pins,
   output logic                match
);

   logic [SECTOR_W-1:0] tag_ff;
   logic                valid_ff, dirty_ff;
   logic [PIN_BITS-1:0] pins_ff;

   always_ff @(posedge clock) begin
      if (sel && cmd.op == OP_FILL) begin
         tag_ff <= cmd.sector;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         pins_ff  <= '0;
      end else if (sel) begin
         unique case (cmd.op)
            OP_HIT: begin
               if (pins_ff != '1) pins_ff <= pins_ff + PIN_BITS'(1);
               if (cmd.wr) dirty_ff <= 1'b1;
            end
            OP_FILL: begin
               valid_ff <= 1'b1;
               dirty_ff <= cmd.wr;
               pins_ff  <= PIN_BITS'(1);
            end
            OP_REL: begin
               if (pins_ff != '0) pins_ff <= pins_ff - PIN_BITS'(1);
               // count ends at zero: the write-back goes out, so drop dirty
               if (pins_ff <= PIN_BITS'(1)) dirty_ff <= 1'b0;
            end
            OP_CLR:  dirty_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   assign tag   = tag_ff;
   assign valid = valid_ff;
   assign dirty = dirty_ff;
   assign pins  = pins_ff;
   assign match = valid_ff && (tag_ff == cmd.sector);

endmodule

// File: rtl/core/scl_ring_cell.sv
// One position of the LRU ring: holds a slot number, takes its neighbor's on shift.
`timescale 1ns / 1ps

module scl_ring_cell #(
   parameter int ID_W     = 3,
   parameter int RESET_ID = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            shift,
   input  logic [ID_W-1:0] shift_in,
   output logic [ID_W-1:0] id
);

   logic [ID_W-1:0] id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= ID_W'(RESET_ID);
      end else if (shift) begin
         id_ff <= shift_in;
      end
   end

   assign id = id_ff;

endmodule

// File: rtl/core/scl_checker.sv
// Port-level assertions for the sector cache LRU controller, bound to the top level.
`timescale 1ns / 1ps

module scl_checker
   import scl_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [FUNC_W-1:0]   req_func,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [REL_W-1:0]    rsp_slot,
   input logic [SECTOR_W-1:0] rsp_slot_sector,
   input logic                rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot)
         && $stable(rsp_slot_sector) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != FUNC_NONE |=> !req_ready)
      else $error("new request taken while one is in flight");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_WB)))
      else $error("last flag does not match result kind");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_HIT || rsp_kind == KIND_WB || rsp_kind == KIND_FILL
         || rsp_kind == KIND_REL_DONE || rsp_kind == KIND_FLUSH_DONE))
      else $error("unknown result kind");

   a_flush_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FLUSH_DONE |-> rsp_slot == '0 && rsp_slot_sector == '0)
      else $error("flush done carries a slot or sector");

endmodule

bind sector_cache_lru_controller scl_checker u_scl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_slot        (rsp_slot),
   .rsp_slot_sector (rsp_slot_sector),
   .rsp_last        (rsp_last)
);
